FILE: design/humidity_sensor_measure_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// humidity sensor measure sequencer assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_MEASURE_SEQUENCER_TOP_MACROS_SVH
`define HUMIDITY_SENSOR_MEASURE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define HSMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hsms check failed");

// next-cycle implication
`define HSMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hsms check failed");

`endif

FILE: design/hsms_pkg.sv
// ----------------------------------------------------------------------------
// hsms_pkg
// types, codes and timing tables of the humidity sensor measure sequencer
// ----------------------------------------------------------------------------
package hsms_pkg;

    localparam int RESET_WAIT_MS  = 15;
    localparam int PERIOD_BASE_MS = 1000;

    localparam int WAIT_W     = 7;
    localparam int CYCLE_W    = 10;
    localparam int CONV_W     = 8;
    localparam int RATE_IDX_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // input kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_COLLECT = 2'd2;
    localparam logic [1:0] KIND_RESET   = 2'd3;

    // bus requests
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // sensor commands
    localparam logic [7:0] CMD_NONE       = 8'h00;
    localparam logic [7:0] CMD_HUMID      = 8'hF5;
    localparam logic [7:0] CMD_TEMP       = 8'hF3;
    localparam logic [7:0] CMD_SOFT_RESET = 8'hFE;

    // sequencer states
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_MEASURE = 3'd2;
    localparam logic [2:0] ST_RESET   = 3'd3;
    localparam logic [2:0] ST_OFF     = 3'd4;

    // awaited bus transaction
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_RESET   = 2'd1;
    localparam logic [1:0] OP_TRIGGER = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RATE_MAX  = 4'd8;
    localparam logic [15:0]           WORD_MASK = 16'hFFFC;

    // conversion times in ms per resolution
    localparam logic [WAIT_W-1:0] HUMID_TIME [4] = '{7'd29, 7'd4, 7'd9, 7'd15};
    localparam logic [WAIT_W-1:0] TEMP_TIME  [4] = '{7'd85, 7'd22, 7'd43, 7'd11};

    // measurement period in ms, indexed by rate minus one
    localparam logic [CYCLE_W-1:0] PERIOD_TAB [8] = '{
        CYCLE_W'(PERIOD_BASE_MS / 1), CYCLE_W'(PERIOD_BASE_MS / 2),
        CYCLE_W'(PERIOD_BASE_MS / 3), CYCLE_W'(PERIOD_BASE_MS / 4),
        CYCLE_W'(PERIOD_BASE_MS / 5), CYCLE_W'(PERIOD_BASE_MS / 6),
        CYCLE_W'(PERIOD_BASE_MS / 7), CYCLE_W'(PERIOD_BASE_MS / 8)
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  bus_request;
        logic [7:0]  command_byte;
        logic [2:0]  sensor_state;
        logic [15:0] temp_raw;
        logic        temp_valid;
        logic [15:0] humid_raw;
        logic        humid_valid;
    } t_out_item;

    typedef struct packed {
        logic               enable;
        logic               force_idle;
        logic [CYCLE_W-1:0] period;
        logic [1:0]         resolution;
    } t_cfg;

endpackage

FILE: design/humidity_sensor_measure_sequencer_top.sv
// ----------------------------------------------------------------------------
// humidity_sensor_measure_sequencer_top
// measurement sequencer for a two-wire humidity/temperature sensor
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_in_valid/o_in_ready, i_in_item) carries events: a 1 ms
//   tick, a finished bus transaction with the two bytes read, a collect, or
//   a soft reset request. every input item yields exactly one result item on
//   the output channel (o_out_valid/i_out_ready, o_out_item): the bus request
//   to queue, the sensor state after the event and the latest raw words.
//   an item taken into the input register is processed in one pass and its
//   result is written to the result register when it advances. throughput
//   is one item per cycle while the receiver does not stall, set by the
//   combinational state update between the input and result registers.
//   a stalled receiver holds the result; the block still takes one more
//   item into its input register and stops taking items after that.
//   reset empties both registers, sets enable 1, rate 1, resolution 0 and
//   puts the sequencer in idle with the cycle countdown expired.
//   configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   once and must be made while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module humidity_sensor_measure_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hsms_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hsms_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [hsms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                   r_in_valid;
    hsms_pkg::t_in_item     r_in_item;
    logic                   r_out_valid;
    hsms_pkg::t_out_item    r_out_item;
    logic                   advance;
    hsms_pkg::t_cfg         cfg;
    hsms_pkg::t_out_item    result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    hsms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hsms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: design/hsms_cfg.sv
// ----------------------------------------------------------------------------
// hsms_cfg
// configuration registers, rate clamp and period lookup
// ----------------------------------------------------------------------------
module hsms_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output hsms_pkg::t_cfg                    o_cfg
);

    logic                              r_enable;
    logic [hsms_pkg::RATE_IDX_W-1:0]   r_rate_idx;
    logic [1:0]                        r_resolution;
    logic                              force_idle;

    // re-enabling from disabled kicks the sequencer back to idle
    assign force_idle = i_cfg_we && (i_cfg_index == hsms_pkg::CFG_ENABLE) &&
                        i_cfg_data[0] && !r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_rate_idx   <= '0;
            r_resolution <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hsms_pkg::CFG_ENABLE: begin
                    r_enable <= i_cfg_data[0];
                end
                hsms_pkg::CFG_RATE: begin
                    // zero keeps the old rate
                    if (i_cfg_data != '0) begin
                        if (i_cfg_data > hsms_pkg::RATE_MAX) begin
                            r_rate_idx <= hsms_pkg::RATE_IDX_W'(hsms_pkg::RATE_MAX - 4'd1);
                        end else begin
                            r_rate_idx <= hsms_pkg::RATE_IDX_W'(i_cfg_data - 4'd1);
                        end
                    end
                end
                hsms_pkg::CFG_RESOLUTION: begin
                    r_resolution <= i_cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.enable     = r_enable;
    assign o_cfg.force_idle = force_idle;
    assign o_cfg.period     = hsms_pkg::PERIOD_TAB[r_rate_idx];
    assign o_cfg.resolution = r_resolution;

endmodule

FILE: design/hsms_core.sv
// ----------------------------------------------------------------------------
// hsms_core
// sequencer state and the single-pass update for one item
// ----------------------------------------------------------------------------
module hsms_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  hsms_pkg::t_in_item    i_item,
    input  hsms_pkg::t_cfg        i_cfg,
    output hsms_pkg::t_out_item   o_result
);

    logic [2:0]                     r_state, n_state;
    logic [1:0]                     r_op, n_op;
    logic                           r_lwh, n_lwh;
    logic [hsms_pkg::WAIT_W-1:0]    r_wait, n_wait;
    logic [hsms_pkg::CYCLE_W-1:0]   r_cycle, n_cycle;
    logic [15:0]                    r_temp, n_temp;
    logic [15:0]                    r_humid, n_humid;
    logic                           r_has_t, n_has_t;
    logic                           r_has_h, n_has_h;

    logic [1:0]                     req;
    logic [7:0]                     cmd;
    logic                           tv, hv;
    logic [hsms_pkg::CONV_W-1:0]    conv;
    logic [hsms_pkg::CYCLE_W-1:0]   conv_ext;
    logic [hsms_pkg::CYCLE_W-1:0]   delay;

    // pause between pairs: period minus both conversion times, floored at zero
    assign conv = hsms_pkg::CONV_W'(hsms_pkg::HUMID_TIME[i_cfg.resolution]) +
                  hsms_pkg::CONV_W'(hsms_pkg::TEMP_TIME[i_cfg.resolution]);
    assign conv_ext = hsms_pkg::CYCLE_W'(conv);
    assign delay = (i_cfg.period > conv_ext) ? (i_cfg.period - conv_ext) : '0;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_lwh   = r_lwh;
        n_wait  = r_wait;
        n_cycle = r_cycle;
        n_temp  = r_temp;
        n_humid = r_humid;
        n_has_t = r_has_t;
        n_has_h = r_has_h;
        req     = hsms_pkg::REQ_NONE;
        cmd     = hsms_pkg::CMD_NONE;
        tv      = 1'b0;
        hv      = 1'b0;
        case (i_item.kind)
            hsms_pkg::KIND_TICK: begin
                if (r_cycle != '0) begin
                    n_cycle = r_cycle - 1'b1;
                end
                if ((r_state == hsms_pkg::ST_MEASURE || r_state == hsms_pkg::ST_RESET) &&
                    r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end
                // decisions use the counts after this tick
                unique case (r_state)
                    hsms_pkg::ST_IDLE: begin
                        if (n_cycle == '0) begin
                            if (i_cfg.enable) begin
                                if (r_lwh) begin
                                    cmd    = hsms_pkg::CMD_TEMP;
                                    n_wait = hsms_pkg::TEMP_TIME[i_cfg.resolution];
                                    n_lwh  = 1'b0;
                                end else begin
                                    cmd    = hsms_pkg::CMD_HUMID;
                                    n_wait = hsms_pkg::HUMID_TIME[i_cfg.resolution];
                                    n_lwh  = 1'b1;
                                end
                                req     = hsms_pkg::REQ_WRITE;
                                n_state = hsms_pkg::ST_PENDING;
                                n_op    = hsms_pkg::OP_TRIGGER;
                            end else begin
                                n_state = hsms_pkg::ST_OFF;
                            end
                        end
                    end
                    hsms_pkg::ST_MEASURE: begin
                        if (n_wait == '0) begin
                            req     = hsms_pkg::REQ_READ;
                            n_state = hsms_pkg::ST_PENDING;
                            n_op    = hsms_pkg::OP_READ;
                            if (r_lwh) begin
                                n_cycle = delay;
                            end
                        end
                    end
                    hsms_pkg::ST_RESET: begin
                        if (n_wait == '0) begin
                            n_state = hsms_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            hsms_pkg::KIND_DONE: begin
                unique case (r_op)
                    hsms_pkg::OP_RESET: begin
                        n_state = hsms_pkg::ST_RESET;
                        n_wait  = hsms_pkg::WAIT_W'(hsms_pkg::RESET_WAIT_MS);
                    end
                    hsms_pkg::OP_TRIGGER: begin
                        n_state = hsms_pkg::ST_MEASURE;
                    end
                    hsms_pkg::OP_READ: begin
                        if (r_lwh) begin
                            n_humid = i_item.data_word & hsms_pkg::WORD_MASK;
                            n_has_h = 1'b1;
                        end else begin
                            n_temp  = i_item.data_word & hsms_pkg::WORD_MASK;
                            n_has_t = 1'b1;
                        end
                        n_state = hsms_pkg::ST_IDLE;
                    end
                    default: begin
                    end
                endcase
                n_op = hsms_pkg::OP_NONE;
            end
            hsms_pkg::KIND_COLLECT: begin
                tv      = r_has_t;
                hv      = r_has_h;
                n_has_t = 1'b0;
                n_has_h = 1'b0;
            end
            default: begin
                req     = hsms_pkg::REQ_WRITE;
                cmd     = hsms_pkg::CMD_SOFT_RESET;
                n_state = hsms_pkg::ST_PENDING;
                n_op    = hsms_pkg::OP_RESET;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsms_pkg::ST_IDLE;
            r_op    <= hsms_pkg::OP_NONE;
            r_lwh   <= 1'b0;
            r_wait  <= '0;
            r_cycle <= '0;
            r_temp  <= '0;
            r_humid <= '0;
            r_has_t <= 1'b0;
            r_has_h <= 1'b0;
        end else begin
            if (i_cfg.force_idle) begin
                r_state <= hsms_pkg::ST_IDLE;
            end else if (i_fire) begin
                r_state <= n_state;
            end
            if (i_fire) begin
                r_op    <= n_op;
                r_lwh   <= n_lwh;
                r_wait  <= n_wait;
                r_cycle <= n_cycle;
                r_temp  <= n_temp;
                r_humid <= n_humid;
                r_has_t <= n_has_t;
                r_has_h <= n_has_h;
            end
        end
    end

    assign o_result.bus_request  = req;
    assign o_result.command_byte = cmd;
    assign o_result.sensor_state = n_state;
    assign o_result.temp_raw     = n_temp;
    assign o_result.temp_valid   = tv;
    assign o_result.humid_raw    = n_humid;
    assign o_result.humid_valid  = hv;

endmodule

FILE: design/hsms_checker.sv
// ----------------------------------------------------------------------------
// hsms_checker
// port-level checks of the measure sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "humidity_sensor_measure_sequencer_top_macros.svh"

module hsms_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  hsms_pkg::t_out_item               o_out_item
);

    logic out_is_write;
    logic out_has_cmd;
    logic out_has_req;
    logic out_pending;
    logic words_clear;

    assign out_is_write = (o_out_item.bus_request == hsms_pkg::REQ_WRITE);
    assign out_has_cmd  = (o_out_item.command_byte != hsms_pkg::CMD_NONE);
    assign out_has_req  = (o_out_item.bus_request != hsms_pkg::REQ_NONE);
    assign out_pending  = (o_out_item.sensor_state == hsms_pkg::ST_PENDING);
    assign words_clear  = (o_out_item.temp_raw[1:0] == 2'b00) &&
                          (o_out_item.humid_raw[1:0] == 2'b00);

    // a stalled item holds
    `HSMS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // a command byte goes out only with a write request
    `HSMS_ASSERT_NOW(a_cmd_with_write, o_out_valid, out_is_write == out_has_cmd)

    // any bus request leaves the sequencer waiting on the bus
    `HSMS_ASSERT_NOW(a_req_pending, o_out_valid && out_has_req, out_pending)

    // stored words always have their status bits cleared
    `HSMS_ASSERT_NOW(a_words_masked, o_out_valid, words_clear)

endmodule

bind humidity_sensor_measure_sequencer_top hsms_checker u_hsms_checker (.*);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the humidity sensor measure sequencer: a local
// model of the sequencer predicts the result item of every event, the bench
// runs directed bring-up events, then model-steered random event streams
// under several register settings with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb;
    import hsms_pkg::*;

    localparam int SETTLE_MS      = 15;
    localparam int PAIR_PERIOD_MS = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // receiver stall patterns
    localparam logic [1:0] RX_STEADY   = 2'd0;
    localparam logic [1:0] RX_SPARSE   = 2'd1;
    localparam logic [1:0] RX_PERIODIC = 2'd2;
    localparam logic [1:0] RX_CHOKED   = 2'd3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // sequencer model, registers and state as after reset
    logic       cfg_enable  = 1'b1;
    logic [3:0] cfg_rate    = 4'd1;
    logic [1:0] cfg_res     = 2'd0;
    logic [2:0] seq_st      = ST_IDLE;
    logic [1:0] awaited_op  = OP_NONE;
    logic       humid_last  = 1'b0;
    logic [6:0] conv_left   = '0;
    logic [9:0] period_left = '0;
    logic [15:0] temp_word  = '0;
    logic [15:0] humid_word = '0;
    logic       temp_new    = 1'b0;
    logic       humid_new   = 1'b0;

    t_out_item event_outcomes[$];
    t_out_item want;
    int        mismatches  = 0;
    int        burst_left  = 0;
    int        idle_cycles = 0;
    int        holds_asked = 0;
    int        holds_done  = 0;
    int        hold_left   = 0;
    int        rx_left     = 0;
    logic [1:0] rx_mode    = RX_STEADY;

    humidity_sensor_measure_sequencer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [6:0] conv_time(input logic humid, input logic [1:0] res);
        case (res)
            2'd0:    return humid ? 7'd29 : 7'd85;
            2'd1:    return humid ? 7'd4  : 7'd22;
            2'd2:    return humid ? 7'd9  : 7'd43;
            default: return humid ? 7'd15 : 7'd11;
        endcase
    endfunction

    // advances the model by one event and returns the result item it causes
    function automatic t_out_item sensor_event(input t_in_item ev);
        t_out_item   res;
        int unsigned span;
        int unsigned conv;
        res = '0;
        res.bus_request  = REQ_NONE;
        res.command_byte = CMD_NONE;
        case (ev.kind)
            KIND_TICK: begin
                if (period_left != 0) period_left = period_left - 1'b1;
                if ((seq_st == ST_MEASURE || seq_st == ST_RESET) && conv_left != 0)
                    conv_left = conv_left - 1'b1;
                case (seq_st)
                    ST_IDLE: begin
                        if (period_left == 0) begin
                            if (cfg_enable) begin
                                res.command_byte = humid_last ? CMD_TEMP : CMD_HUMID;
                                conv_left        = conv_time(!humid_last, cfg_res);
                                humid_last       = !humid_last;
                                res.bus_request  = REQ_WRITE;
                                seq_st           = ST_PENDING;
                                awaited_op       = OP_TRIGGER;
                            end else begin
                                seq_st = ST_OFF;
                            end
                        end
                    end
                    ST_MEASURE: begin
                        if (conv_left == 0) begin
                            res.bus_request = REQ_READ;
                            seq_st          = ST_PENDING;
                            awaited_op      = OP_READ;
                            if (humid_last) begin
                                // rest of the period after both conversions
                                span = PAIR_PERIOD_MS / cfg_rate;
                                conv = int'(conv_time(1'b1, cfg_res)) +
                                       int'(conv_time(1'b0, cfg_res));
                                period_left = (span > conv) ? 10'(span - conv) : 10'd0;
                            end
                        end
                    end
                    ST_RESET: begin
                        if (conv_left == 0) seq_st = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            KIND_DONE: begin
                case (awaited_op)
                    OP_RESET: begin
                        seq_st    = ST_RESET;
                        conv_left = 7'(SETTLE_MS);
                    end
                    OP_TRIGGER: seq_st = ST_MEASURE;
                    OP_READ: begin
                        if (humid_last) begin
                            humid_word = ev.data_word & 16'hFFFC;
                            humid_new  = 1'b1;
                        end else begin
                            temp_word = ev.data_word & 16'hFFFC;
                            temp_new  = 1'b1;
                        end
                        seq_st = ST_IDLE;
                    end
                    default: ;
                endcase
                awaited_op = OP_NONE;
            end
            KIND_COLLECT: begin
                res.temp_valid  = temp_new;
                res.humid_valid = humid_new;
                temp_new        = 1'b0;
                humid_new       = 1'b0;
            end
            default: begin
                res.bus_request  = REQ_WRITE;
                res.command_byte = CMD_SOFT_RESET;
                seq_st           = ST_PENDING;
                awaited_op       = OP_RESET;
            end
        endcase
        res.sensor_state = seq_st;
        res.temp_raw     = temp_word;
        res.humid_raw    = humid_word;
        return res;
    endfunction

    // mostly completes what the sequencer waits for, the rest is noise
    function automatic t_in_item pick_event();
        t_in_item ev;
        int       r;
        r = $urandom_range(0, 999);
        case ($urandom_range(0, 9))
            0:       ev.data_word = 16'h0000;
            1:       ev.data_word = 16'hFFFF;
            default: ev.data_word = 16'($urandom_range(0, 16'hFFFF));
        endcase
        if (seq_st == ST_PENDING) begin
            if (r < 800)      ev.kind = KIND_DONE;
            else if (r < 900) ev.kind = KIND_TICK;
            else if (r < 980) ev.kind = KIND_COLLECT;
            else              ev.kind = KIND_RESET;
        end else begin
            if (r < 930)      ev.kind = KIND_TICK;
            else if (r < 970) ev.kind = KIND_COLLECT;
            else if (r < 995) ev.kind = KIND_DONE;
            else              ev.kind = KIND_RESET;
        end
        return ev;
    endfunction

    // valid stays high after an accepted item unless a gap follows
    task automatic send_event(input t_in_item ev);
        in_valid <= 1'b1;
        in_item  <= ev;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        event_outcomes.push_back(sensor_event(ev));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    task automatic post_event(input logic [1:0] kind, input logic [15:0] data);
        t_in_item ev;
        ev.kind      = kind;
        ev.data_word = data;
        send_event(ev);
    endtask

    task automatic run_random_events(input int count);
        repeat (count) send_event(pick_event());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (event_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ENABLE: begin
                if (val[0]) begin
                    // re-enable forces idle
                    if (!cfg_enable) begin
                        seq_st     = ST_IDLE;
                        cfg_enable = 1'b1;
                    end
                end else begin
                    cfg_enable = 1'b0;
                end
            end
            CFG_RATE: begin
                if (val != 0) cfg_rate = (val > RATE_MAX) ? RATE_MAX : val;
            end
            CFG_RESOLUTION: cfg_res = val[1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_bring_up();
        write_register(CFG_RESOLUTION, 4'd1);
        write_register(CFG_RATE, 4'd8);
        post_event(KIND_COLLECT, 16'h0000);
        post_event(KIND_DONE, 16'hFFFF);     // nothing awaited
        post_event(KIND_TICK, 16'h0000);     // humidity trigger
        drain_results();
        // toggling enable forces idle while the trigger is still awaited
        write_register(CFG_ENABLE, 4'hE);
        write_register(CFG_ENABLE, 4'h1);
        post_event(KIND_DONE, 16'h1234);     // completion outside pending
        repeat (4) post_event(KIND_TICK, 16'hFFFF);
        post_event(KIND_DONE, 16'hFFFF);
        post_event(KIND_COLLECT, 16'hFFFF);
        post_event(KIND_COLLECT, 16'h0000);
        post_event(KIND_TICK, 16'h0000);
        post_event(KIND_RESET, 16'h0000);
        post_event(KIND_RESET, 16'hFFFF);    // replaces the awaited reset
        post_event(KIND_DONE, 16'h0000);
        post_event(KIND_TICK, 16'h5555);
        post_event(KIND_RESET, 16'hAAAA);
        post_event(KIND_DONE, 16'h0003);
        drain_results();
    endtask

    task automatic test_measure_cycles();
        run_random_events(350);
        drain_results();
        write_register(CFG_RESOLUTION, 4'd0);
        run_random_events(250);
        drain_results();
        write_register(CFG_RATE, 4'hF);      // clamps to the top rate
        write_register(CFG_RESOLUTION, 4'd3);
        run_random_events(250);
        drain_results();
        write_register(CFG_RATE, 4'd0);      // ignored
        write_register(CFG_RESOLUTION, 4'd2);
        run_random_events(100);
        drain_results();
        write_register(CFG_RATE, 4'd4);
        run_random_events(200);
        drain_results();
    endtask

    task automatic test_disable_enable();
        write_register(CFG_ENABLE, 4'hE);
        run_random_events(100);
        drain_results();
        write_register(CFG_ENABLE, 4'hF);
        write_register(CFG_RATE, 4'd1);
        write_register(CFG_RESOLUTION, 4'd0);
        run_random_events(150);
        drain_results();
        write_register(CFG_ENABLE, 4'h1);
        write_register(CFG_SPARE, 4'h5);
        write_register(CFG_RATE, 4'd8);
        write_register(CFG_RESOLUTION, 4'd1);
        run_random_events(150);
        drain_results();
    endtask

    task automatic test_output_holdoff();
        holds_asked++;
        run_random_events(100);
        drain_results();
    endtask

    task automatic test_sender_pause();
        repeat (6) begin
            run_random_events($urandom_range(5, 20));
            drain_results();
        end
    endtask

    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY:   out_ready <= 1'b1;
                RX_SPARSE:   out_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: out_ready <= (rx_left[1:0] != 2'b00);
                default:     out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (event_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: req=%0d cmd=%02h st=%0d",
                             out_item.bus_request, out_item.command_byte,
                             out_item.sensor_state);
            end else begin
                want = event_outcomes.pop_front();
                if (want.bus_request !== out_item.bus_request ||
                    want.command_byte !== out_item.command_byte ||
                    want.sensor_state !== out_item.sensor_state ||
                    want.temp_raw !== out_item.temp_raw ||
                    want.temp_valid !== out_item.temp_valid ||
                    want.humid_raw !== out_item.humid_raw ||
                    want.humid_valid !== out_item.humid_valid) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected req=%0d cmd=%02h st=%0d t=%04h/%0d h=%04h/%0d",
                                 want.bus_request, want.command_byte, want.sensor_state,
                                 want.temp_raw, want.temp_valid, want.humid_raw,
                                 want.humid_valid);
                        $display("          got      req=%0d cmd=%02h st=%0d t=%04h/%0d h=%04h/%0d",
                                 out_item.bus_request, out_item.command_byte,
                                 out_item.sensor_state, out_item.temp_raw,
                                 out_item.temp_valid, out_item.humid_raw,
                                 out_item.humid_valid);
                    end
                end
            end
        end
    end

    // ends a hung run
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bring_up();
        test_measure_cycles();
        test_disable_enable();
        test_output_holdoff();
        test_sender_pause();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && event_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
